FILE: rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg - shared types and constants of the thread dispatcher
// Opcodes, policy codes, the item, state and result records, and helpers
// that widen time values for overflow-free sums.
// ----------------------------------------------------------------------------
package rtd_pkg;

	localparam int TIME_BITS_DEFAULT = 32;
	// 34 bits hold any difference or sum of two 32-bit times without overflow
	localparam int WIDE_BITS = 34;
	localparam logic signed [31:0] NO_RELEASE = 32'sh7fffffff;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_RUN     = 2'd1,
		OP_RELEASE = 2'd2,
		OP_DECIDE  = 2'd3
	} op_t;

	localparam logic [1:0] MODE_LOWID = 2'd0;
	localparam logic [1:0] MODE_EDF   = 2'd1;
	localparam logic [1:0] MODE_RM    = 2'd2;

	localparam logic REG_POLICY_MODE = 1'b0;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] now_time;
		logic [15:0]        thread_id;
		logic [30:0]        thread_period;
		logic signed [31:0] thread_deadline;
		logic [30:0]        thread_remaining;
		logic signed [31:0] release_at;
	} rtd_item_t;

	typedef struct packed {
		logic signed [31:0] latched_now;
		logic               lowid_valid;
		logic [15:0]        lowid_id;
		logic [30:0]        lowid_remaining;
		logic               edf_valid;
		logic [15:0]        edf_id;
		logic signed [31:0] edf_deadline;
		logic [30:0]        edf_remaining;
		logic               expired_valid;
		logic [15:0]        expired_id;
		logic               rm_valid;
		logic [15:0]        rm_id;
		logic [30:0]        rm_period;
		logic signed [31:0] rm_deadline;
		logic [30:0]        rm_remaining;
		logic signed [31:0] preempt_release;
		logic signed [31:0] earliest_release;
	} rtd_state_t;

	typedef struct packed {
		logic               thread_chosen;
		logic               deadline_expired;
		logic [15:0]        chosen_id;
		logic signed [31:0] slice_ticks;
	} rtd_result_t;

	function automatic logic signed [WIDE_BITS-1:0] wide_s(input logic signed [31:0] v);
		return WIDE_BITS'(v);
	endfunction

	function automatic logic signed [WIDE_BITS-1:0] wide_u(input logic [30:0] v);
		return $signed(WIDE_BITS'(v));
	endfunction

endpackage

FILE: rtl/rtd_chan_if.sv
// ----------------------------------------------------------------------------
// rtd_chan_if - valid/ready channels of the thread dispatcher
// Item channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface rtd_item_if import rtd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] now_time;
	logic [15:0]        thread_id;
	logic [30:0]        thread_period;
	logic signed [31:0] thread_deadline;
	logic [30:0]        thread_remaining;
	logic signed [31:0] release_at;

	modport source (
		output valid, opcode, now_time, thread_id, thread_period,
		       thread_deadline, thread_remaining, release_at,
		input  ready
	);
	modport sink (
		input  valid, opcode, now_time, thread_id, thread_period,
		       thread_deadline, thread_remaining, release_at,
		output ready
	);
endinterface

interface rtd_result_if import rtd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               thread_chosen;
	logic               deadline_expired;
	logic [15:0]        chosen_id;
	logic signed [31:0] slice_ticks;

	modport source (
		output valid, thread_chosen, deadline_expired, chosen_id, slice_ticks,
		input  ready
	);
	modport sink (
		input  valid, thread_chosen, deadline_expired, chosen_id, slice_ticks,
		output ready
	);
endinterface

FILE: rtl/rtd_cfg.sv
// ----------------------------------------------------------------------------
// rtd_cfg - register port of the thread dispatcher
// Holds the policy mode; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module rtd_cfg import rtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [1:0]  mode
);
	logic [1:0] mode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_POLICY_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LOWID;
		end else if (wr_en) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == REG_POLICY_MODE) ? {30'd0, mode_q} : 32'd0;
	assign mode   = mode_q;

endmodule

FILE: rtl/rtd_track.sv
// ----------------------------------------------------------------------------
// rtd_track - running bests of the thread dispatcher
// Applies one word per cycle while upd is high to the per-policy best threads and release minima.
// ----------------------------------------------------------------------------
module rtd_track import rtd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd,
	input  rtd_item_t  item,
	input  logic [1:0] mode,
	output rtd_state_t st
);
	localparam rtd_state_t ST_RESET = '{
		preempt_release:  NO_RELEASE,
		earliest_release: NO_RELEASE,
		default:          '0
	};

	rtd_state_t st_q;
	rtd_state_t nxt;
	rtd_state_t cleared;
	logic signed [WIDE_BITS-1:0] rel_end;

	always_comb begin
		cleared = '0;
		cleared.latched_now      = item.now_time;
		cleared.preempt_release  = NO_RELEASE;
		cleared.earliest_release = NO_RELEASE;
	end

	assign rel_end = wide_s(item.release_at) + wide_u(item.thread_period);

	always_comb begin
		nxt = st_q;
		case (item.opcode)
			OP_BEGIN: begin
				nxt = cleared;
			end
			OP_RUN: begin
				if (!st_q.lowid_valid || item.thread_id < st_q.lowid_id) begin
					nxt.lowid_valid     = 1'b1;
					nxt.lowid_id        = item.thread_id;
					nxt.lowid_remaining = item.thread_remaining;
				end
				if (!st_q.edf_valid || item.thread_deadline < st_q.edf_deadline ||
				    (item.thread_deadline == st_q.edf_deadline &&
				     item.thread_id < st_q.edf_id)) begin
					nxt.edf_valid     = 1'b1;
					nxt.edf_id        = item.thread_id;
					nxt.edf_deadline  = item.thread_deadline;
					nxt.edf_remaining = item.thread_remaining;
				end
				if (item.thread_deadline <= st_q.latched_now &&
				    (!st_q.expired_valid || item.thread_id < st_q.expired_id)) begin
					nxt.expired_valid = 1'b1;
					nxt.expired_id    = item.thread_id;
				end
				if (!st_q.rm_valid || item.thread_period < st_q.rm_period ||
				    (item.thread_period == st_q.rm_period &&
				     item.thread_id < st_q.rm_id)) begin
					nxt.rm_valid     = 1'b1;
					nxt.rm_id        = item.thread_id;
					nxt.rm_period    = item.thread_period;
					nxt.rm_deadline  = item.thread_deadline;
					nxt.rm_remaining = item.thread_remaining;
				end
			end
			OP_RELEASE: begin
				if (item.release_at < st_q.earliest_release) begin
					nxt.earliest_release = item.release_at;
				end
				// preemption only tracked against the active policy's target
				if (mode == MODE_EDF && st_q.edf_valid) begin
					if (rel_end < wide_s(st_q.edf_deadline) &&
					    item.release_at < st_q.preempt_release) begin
						nxt.preempt_release = item.release_at;
					end
				end else if (mode == MODE_RM && st_q.rm_valid) begin
					if (item.thread_period < st_q.rm_period &&
					    item.release_at < st_q.preempt_release) begin
						nxt.preempt_release = item.release_at;
					end
				end
			end
			default: begin
				nxt = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (upd) begin
			st_q <= nxt;
		end
	end

	assign st = st_q;

endmodule

FILE: rtl/rtd_decide.sv
// ----------------------------------------------------------------------------
// rtd_decide - decision logic of the thread dispatcher
// Forms the chosen thread and its saturated slice from the running bests.
// ----------------------------------------------------------------------------
module rtd_decide import rtd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  rtd_state_t  st,
	input  logic [1:0]  mode,
	output rtd_result_t res
);
	localparam int SLICE_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;
	localparam logic signed [WIDE_BITS-1:0] SAT_HI =
		$signed((WIDE_BITS'(1) << (SLICE_BITS - 1)) - WIDE_BITS'(1));
	localparam logic signed [WIDE_BITS-1:0] SAT_LO = -SAT_HI - WIDE_BITS'(1);

	logic                        tgt_valid;
	logic signed [31:0]          tgt_dl;
	logic [30:0]                 tgt_rem;
	logic [15:0]                 tgt_id;
	logic signed [31:0]          limit;
	logic signed [WIDE_BITS-1:0] slice;

	always_comb begin
		tgt_valid = (mode == MODE_EDF) ? st.edf_valid     : st.rm_valid;
		tgt_dl    = (mode == MODE_EDF) ? st.edf_deadline  : st.rm_deadline;
		tgt_rem   = (mode == MODE_EDF) ? st.edf_remaining : st.rm_remaining;
		tgt_id    = (mode == MODE_EDF) ? st.edf_id        : st.rm_id;
		limit     = (tgt_dl < st.preempt_release) ? tgt_dl : st.preempt_release;

		res.thread_chosen    = 1'b0;
		res.deadline_expired = 1'b0;
		res.chosen_id        = 16'd0;
		slice                = WIDE_BITS'(1);

		if (mode inside {MODE_EDF, MODE_RM}) begin
			if (mode == MODE_RM && st.expired_valid) begin
				res.thread_chosen    = 1'b1;
				res.deadline_expired = 1'b1;
				res.chosen_id        = st.expired_id;
				slice                = '0;
			end else if (tgt_valid) begin
				slice = wide_s(limit) - wide_s(st.latched_now);
				if (wide_u(tgt_rem) < slice) begin
					slice = wide_u(tgt_rem);
				end
				if (mode == MODE_RM && slice < 0) begin
					slice = '0;
				end
				res.thread_chosen = 1'b1;
				res.chosen_id     = tgt_id;
			end else begin
				// idle until the next release
				slice = wide_s(st.earliest_release) - wide_s(st.latched_now);
			end
		end else if (st.lowid_valid) begin
			res.thread_chosen = 1'b1;
			res.chosen_id     = st.lowid_id;
			slice             = wide_u(st.lowid_remaining);
		end

		if (slice > SAT_HI) begin
			slice = SAT_HI;
		end else if (slice < SAT_LO) begin
			slice = SAT_LO;
		end
		res.slice_ticks = slice[31:0];
	end

endmodule

FILE: rtl/realtime_thread_dispatch.sv
// ----------------------------------------------------------------------------
// realtime_thread_dispatch - EDF / rate monotonic / lowest-id dispatcher
// Builds one dispatch decision from a stream of begin, run, release and
// decide words; answers each decide with the chosen thread and its slice.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           word
//  items     in    valid/ready         opcode + thread and time fields
//  results   out   valid/ready         chosen flag, expired flag, id, slice
//  apb       in    psel/penable/pready policy_mode at address 0
//
//  One word per cycle while no decide waits on a full result register;
//  the running bests are updated between the input register and the
//  state registers. A decide answer passes the input register, then
//  the result register; other words produce nothing.
//  Reset is asynchronous and brings up cleared bests, mode lowest id.
//  A waiting result stalls only a decide word held in the input register;
//  begin, run and release words keep flowing past it.
//
module realtime_thread_dispatch import rtd_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	rtd_item_if.sink     items,
	rtd_result_if.source results,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	logic [1:0]  mode;
	rtd_item_t   item_s1;
	logic        valid_s1;
	logic        adv_s1;
	logic        take;
	logic        is_decide_s1;
	rtd_state_t  st;
	rtd_result_t res;
	rtd_result_t result_q;
	logic        out_valid_q;

	rtd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	// input register: a decide waits here only while the result register is full
	assign is_decide_s1 = (item_s1.opcode == OP_DECIDE);
	assign adv_s1       = valid_s1 && (!is_decide_s1 || !out_valid_q || results.ready);
	assign items.ready  = !valid_s1 || adv_s1;
	assign take         = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{
				opcode:           items.opcode,
				now_time:         items.now_time,
				thread_id:        items.thread_id,
				thread_period:    items.thread_period,
				thread_deadline:  items.thread_deadline,
				thread_remaining: items.thread_remaining,
				release_at:       items.release_at
			};
		end
	end

	// state is updated as the word leaves the input register
	rtd_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s1),
		.item   (item_s1),
		.mode   (mode),
		.st     (st)
	);

	// a decide reads the state left by every earlier word
	rtd_decide #(
		.TIME_BITS (TIME_BITS)
	) u_decide (
		.st   (st),
		.mode (mode),
		.res  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_decide_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_decide_s1) begin
			result_q <= res;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.thread_chosen    = result_q.thread_chosen;
	assign results.deadline_expired = result_q.deadline_expired;
	assign results.chosen_id        = result_q.chosen_id;
	assign results.slice_ticks      = result_q.slice_ticks;

`ifndef NO_ASSERTIONS
	// a new result only follows a decide leaving the input register
	a_result_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && is_decide_s1))
		else $error("result raised without a decide");

	// back-pressure only from a decide blocked by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> (valid_s1 && is_decide_s1 && out_valid_q && !results.ready))
		else $error("input stalled without cause");

	// begin clears every running best
	a_begin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.opcode == OP_BEGIN) |=>
		(!st.lowid_valid && !st.edf_valid && !st.expired_valid && !st.rm_valid &&
		 st.earliest_release == NO_RELEASE && st.preempt_release == NO_RELEASE))
		else $error("begin left stale bests");
`endif

endmodule

FILE: tb/sv/realtime_thread_dispatch_tb.sv
// ----------------------------------------------------------------------------
// realtime_thread_dispatch_tb - self-checking bench of the thread dispatcher
// Streams begin / run / release / decide words through the item channel
// under all three policies, keeps its own model of the running bests and
// compares each decide answer field by field, with random idling on both
// channels and policy changes between idle phases.
// ----------------------------------------------------------------------------
module realtime_thread_dispatch_tb;
	import rtd_pkg::*;

	localparam logic signed [31:0] TMIN = 32'sh80000000;
	localparam logic signed [31:0] TMAX = 32'sh7fffffff;
	localparam logic [30:0]        UMAX = 31'h7fffffff;
	localparam int                 RANDOM_WORDS = 1850;

	// Model of the dispatcher: running bests per policy plus the queue of
	// decide answers still owed by the block.
	class dispatch_tracker;
		logic [1:0]  mode;
		longint      now_t;
		bit          lo_v;
		logic [15:0] lo_id;
		longint      lo_rem;
		bit          edf_v;
		logic [15:0] edf_id;
		longint      edf_dl, edf_rem;
		bit          exp_v;
		logic [15:0] exp_id;
		bit          rm_v;
		logic [15:0] rm_id;
		longint      rm_per, rm_dl, rm_rem;
		longint      preempt, earliest;
		rtd_result_t answers[$];
		int          errors;

		function new();
			mode = MODE_LOWID;
			now_t = 0;
			errors = 0;
			clear();
		endfunction

		function void clear();
			lo_v = 0; lo_id = 0; lo_rem = 0;
			edf_v = 0; edf_id = 0; edf_dl = 0; edf_rem = 0;
			exp_v = 0; exp_id = 0;
			rm_v = 0; rm_id = 0; rm_per = 0; rm_dl = 0; rm_rem = 0;
			preempt = longint'(NO_RELEASE);
			earliest = longint'(NO_RELEASE);
		endfunction

		// Accepted item word: update bests, or owe an answer on decide.
		function void take_word(rtd_item_t w);
			longint      dl, rel, per, rem, x, sl;
			logic [15:0] id;
			rtd_result_t a;
			id  = w.thread_id;
			dl  = longint'($signed(w.thread_deadline));
			rel = longint'($signed(w.release_at));
			per = longint'(w.thread_period);
			rem = longint'(w.thread_remaining);
			case (w.opcode)
				OP_BEGIN: begin
					now_t = longint'($signed(w.now_time));
					clear();
				end
				OP_RUN: begin
					if (!lo_v || id < lo_id) begin
						lo_v = 1; lo_id = id; lo_rem = rem;
					end
					if (!edf_v || dl < edf_dl || (dl == edf_dl && id < edf_id)) begin
						edf_v = 1; edf_id = id; edf_dl = dl; edf_rem = rem;
					end
					if (dl <= now_t && (!exp_v || id < exp_id)) begin
						exp_v = 1; exp_id = id;
					end
					if (!rm_v || per < rm_per || (per == rm_per && id < rm_id)) begin
						rm_v = 1; rm_id = id; rm_per = per; rm_dl = dl; rm_rem = rem;
					end
				end
				OP_RELEASE: begin
					if (rel < earliest)
						earliest = rel;
					// preemption only counts against an existing target
					if (mode == MODE_EDF && edf_v) begin
						if (rel + per < edf_dl && rel < preempt)
							preempt = rel;
					end else if (mode == MODE_RM && rm_v) begin
						if (per < rm_per && rel < preempt)
							preempt = rel;
					end
				end
				default: begin
					a = '0;
					sl = 0;
					if (mode == MODE_EDF || mode == MODE_RM) begin
						if (mode == MODE_RM && exp_v) begin
							a.thread_chosen = 1;
							a.deadline_expired = 1;
							a.chosen_id = exp_id;
						end else if (mode == MODE_EDF ? edf_v : rm_v) begin
							dl  = (mode == MODE_EDF) ? edf_dl : rm_dl;
							rem = (mode == MODE_EDF) ? edf_rem : rm_rem;
							x = (dl < preempt) ? dl : preempt;
							sl = x - now_t;
							if (rem < sl)
								sl = rem;
							if (mode == MODE_RM && sl < 0)
								sl = 0;
							a.thread_chosen = 1;
							a.chosen_id = (mode == MODE_EDF) ? edf_id : rm_id;
						end else begin
							sl = earliest - now_t;
						end
					end else if (lo_v) begin
						a.thread_chosen = 1;
						a.chosen_id = lo_id;
						sl = lo_rem;
					end else begin
						sl = 1;
					end
					if (sl > 64'sd2147483647)
						sl = 64'sd2147483647;
					if (sl < -64'sd2147483648)
						sl = -64'sd2147483648;
					a.slice_ticks = sl[31:0];
					answers.push_back(a);
				end
			endcase
		endfunction

		function void match_answer(rtd_result_t got);
			rtd_result_t want;
			if (answers.size() == 0) begin
				$error("result word with no decide pending");
				errors++;
				return;
			end
			want = answers.pop_front();
			if (got.thread_chosen !== want.thread_chosen) begin
				$error("thread_chosen: expected %0d, actual %0d",
					want.thread_chosen, got.thread_chosen);
				errors++;
			end
			if (got.deadline_expired !== want.deadline_expired) begin
				$error("deadline_expired: expected %0d, actual %0d",
					want.deadline_expired, got.deadline_expired);
				errors++;
			end
			if (got.chosen_id !== want.chosen_id) begin
				$error("chosen_id: expected %0d, actual %0d",
					want.chosen_id, got.chosen_id);
				errors++;
			end
			if (got.slice_ticks !== want.slice_ticks) begin
				$error("slice_ticks: expected %0d, actual %0d",
					$signed(want.slice_ticks), $signed(got.slice_ticks));
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// calm: a phase with no idling on either channel
	bit              calm = 1'b0;
	int              words_sent = 0;
	dispatch_tracker tracker = new();

	rtd_item_if   items_if();
	rtd_result_if results_if();

	realtime_thread_dispatch uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Fixed word builder for the directed part.
	function automatic rtd_item_t mk(input logic [1:0] op, input logic signed [31:0] now,
			input logic [15:0] id, input logic [30:0] per, input logic signed [31:0] dl,
			input logic [30:0] rem, input logic signed [31:0] rel);
		rtd_item_t w;
		w.opcode = op;
		w.now_time = now;
		w.thread_id = id;
		w.thread_period = per;
		w.thread_deadline = dl;
		w.thread_remaining = rem;
		w.release_at = rel;
		return w;
	endfunction

	// Tick close to the latched time most of the time, so deadlines expire,
	// releases preempt and slices clamp; full range otherwise.
	function automatic logic signed [31:0] near_tick(input logic signed [31:0] base);
		int b;
		b = base;
		if ($urandom_range(0, 9) < 3)
			return $urandom;
		return b + int'($urandom_range(0, 400)) - 200;
	endfunction

	// Period / remaining: small values for ties half the time.
	function automatic logic [30:0] rand_span();
		if ($urandom_range(0, 1) == 1)
			return 31'($urandom_range(0, 30));
		return 31'($urandom);
	endfunction

	function automatic rtd_item_t shaped_word(input logic [1:0] op,
			input logic signed [31:0] base);
		rtd_item_t w;
		w.opcode = op;
		w.now_time = (op == OP_BEGIN) ? base : $urandom;
		w.thread_id = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
		w.thread_period = rand_span();
		w.thread_deadline = near_tick(base);
		w.thread_remaining = rand_span();
		w.release_at = near_tick(base);
		return w;
	endfunction

	// Item channel driver: random gap, then hold the word until taken.
	// valid stays high across back-to-back words.
	task automatic send_word(input rtd_item_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.opcode <= w.opcode;
		items_if.now_time <= w.now_time;
		items_if.thread_id <= w.thread_id;
		items_if.thread_period <= w.thread_period;
		items_if.thread_deadline <= w.thread_deadline;
		items_if.thread_remaining <= w.thread_remaining;
		items_if.release_at <= w.release_at;
		do @(posedge clk); while (!items_if.ready);
		tracker.take_word(w);
		words_sent++;
	endtask

	// Drain: stop sending, wait for every owed answer, then let the
	// two-stage pipe empty of non-decide words too.
	task automatic settle();
		items_if.valid <= 1'b0;
		while (tracker.answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write of policy_mode: setup phase, then access until pready.
	task automatic write_mode(input logic [1:0] m);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_POLICY_MODE, 2'b00};
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.mode = m;
	endtask

	// Result channel: random stall before each word, ready held until taken.
	initial begin
		int          stall;
		rtd_result_t got;
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do @(posedge clk); while (!results_if.valid);
			got.thread_chosen = results_if.thread_chosen;
			got.deadline_expired = results_if.deadline_expired;
			got.chosen_id = results_if.chosen_id;
			got.slice_ticks = results_if.slice_ticks;
			tracker.match_answer(got);
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int                 start_count, phase, kind, nrun, nrel;
		logic signed [31:0] base;
		arst_n = 1'b0;
		items_if.valid <= 1'b0;
		items_if.opcode <= OP_BEGIN;
		items_if.now_time <= '0;
		items_if.thread_id <= '0;
		items_if.thread_period <= '0;
		items_if.thread_deadline <= '0;
		items_if.thread_remaining <= '0;
		items_if.release_at <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, lowest id policy out of reset ---
		// decide on reset state: idle, one tick
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		// run word before any begin works on reset state
		send_word(mk(OP_RUN, 0, 16'hffff, UMAX, TMAX, UMAX, 0));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_BEGIN, TMIN, 0, 0, 0, 0, 0));
		send_word(mk(OP_RUN, 0, 0, 0, TMIN, 0, 0));
		send_word(mk(OP_RELEASE, 0, 0, UMAX, 0, 0, TMAX));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		settle();

		// --- directed, EDF ---
		write_mode(MODE_EDF);
		send_word(mk(OP_BEGIN, TMAX, 0, 0, 0, 0, 0));
		// idle with no release: slice is the sentinel minus now, zero here
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		// release with no target yet only moves earliest release
		send_word(mk(OP_RELEASE, 0, 0, 0, 0, 0, TMIN));
		// idle slice underflows and saturates low
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		// equal deadlines: lower id wins
		send_word(mk(OP_RUN, 0, 5, 7, 100, 50, 0));
		send_word(mk(OP_RUN, 0, 3, 7, 100, UMAX, 0));
		// wide sum of release and period must not wrap
		send_word(mk(OP_RELEASE, 0, 0, UMAX, 0, 0, TMIN));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		settle();

		// --- directed, rate monotonic ---
		write_mode(MODE_RM);
		send_word(mk(OP_BEGIN, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_RUN, 0, 9, 10, 50, 20, 0));
		// shorter period release cuts the slice
		send_word(mk(OP_RELEASE, 0, 0, 3, 0, 0, 5));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		// expired thread takes priority with a zero slice
		send_word(mk(OP_RUN, 0, 4, 20, 0, 9, 0));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));
		// negative slice clamps to zero
		send_word(mk(OP_BEGIN, 1000, 0, 0, 0, 0, 0));
		send_word(mk(OP_RUN, 0, 1, 1, 1001, 5, 0));
		send_word(mk(OP_RELEASE, 0, 0, 0, 0, 0, -5));
		send_word(mk(OP_DECIDE, 0, 0, 0, 0, 0, 0));

		// --- random phases; each phase starts drained, then picks a policy ---
		start_count = words_sent;
		phase = 0;
		while (words_sent - start_count < RANDOM_WORDS) begin
			settle();
			write_mode((phase < 3) ? 2'(phase) : 2'($urandom_range(0, 2)));
			calm = ($urandom_range(0, 3) == 0);
			repeat (25) begin
				kind = $urandom_range(0, 9);
				case ($urandom_range(0, 9))
					0: base = TMIN;
					1: base = TMAX;
					2: base = 0;
					default: base = $urandom;
				endcase
				if (kind == 0) begin
					// noise: any opcode, any order
					repeat ($urandom_range(1, 6))
						send_word(shaped_word(2'($urandom), base));
				end else begin
					// kind 2 skips begin and builds on the previous decision;
					// kind 1 interleaves run and release words
					if (kind != 2)
						send_word(shaped_word(OP_BEGIN, base));
					nrun = $urandom_range(0, 6);
					nrel = $urandom_range(0, 4);
					if (kind == 1) begin
						repeat (nrun + nrel)
							send_word(shaped_word(($urandom_range(0, 1) == 1) ?
								OP_RUN : OP_RELEASE, base));
					end else begin
						repeat (nrun) send_word(shaped_word(OP_RUN, base));
						repeat (nrel) send_word(shaped_word(OP_RELEASE, base));
					end
					send_word(shaped_word(OP_DECIDE, base));
					// repeated decide must give the same answer
					if ($urandom_range(0, 4) == 0)
						send_word(shaped_word(OP_DECIDE, base));
				end
			end
			phase++;
		end

		settle();
		if (tracker.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: realtime_thread_dispatch.f
rtl/rtd_pkg.sv
rtl/rtd_chan_if.sv
rtl/rtd_cfg.sv
rtl/rtd_track.sv
rtl/rtd_decide.sv
rtl/realtime_thread_dispatch.sv
tb/sv/realtime_thread_dispatch_tb.sv
